/* design/rpc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the ROM page cache core.
// Used by the core, the entry RAM and the port checker.
package rpc_pkg;

  localparam int SLOTS_DEF       = 16;
  localparam int PAGE_BITS       = 12;
  localparam int ADDR_BITS       = 23;
  localparam int FIXED_BANK_SIZE = 32 * 1024;
  localparam int TAG_W           = ADDR_BITS - PAGE_BITS;
  localparam int LEN_W           = PAGE_BITS + 1;
  localparam int PAGE_SIZE       = 1 << PAGE_BITS;
  localparam int ROM_LEN_W       = 24;
  localparam int SLOTS_CFG_W     = 5;
  localparam int SLOT_W          = 4;
  localparam int STAMP_W         = 32;
  localparam int CFG_IDX_W       = 2;
  localparam int SLOTS_RESET     = 16;

  typedef enum logic [2:0] {
    ST_OOR   = 3'd0,
    ST_FIXED = 3'd1,
    ST_HIT   = 3'd2,
    ST_MISS  = 3'd3,
    ST_FLUSH = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROM_LENGTH   = 2'd0,
    REG_SLOTS_IN_USE = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic                 req_type;
    logic [ADDR_BITS-1:0] address;
  } in_t;

  typedef struct packed {
    status_t              status;
    logic [SLOT_W-1:0]    slot;
    logic [PAGE_BITS-1:0] offset;
    logic [TAG_W-1:0]     fill_page;
    logic [LEN_W-1:0]     fill_length;
    logic                 evicted_valid;
  } out_t;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

endpackage

/* design/rpc_entry_ram.sv */
`timescale 1ns / 1ps
// Slot entry RAM (page tag and use stamp), one write and one read port.
// Read data registered; entry type from rpc_pkg.
module rpc_entry_ram #(
  parameter int DEPTH = rpc_pkg::SLOTS_DEF,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  rpc_pkg::entry_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output rpc_pkg::entry_t rd_data
);

  rpc_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/rom_page_cache_lru_core.sv */
`timescale 1ns / 1ps
// ROM page cache core: address classification, slot lookup, LRU fill.
// Depends on rpc_pkg and rpc_entry_ram.
//
// One transaction is worked on at a time. A flush, an out-of-range or a
// fixed-bank read is answered without a walk. For a paged read, the
// single read port of the entry RAM walks the active slots (slots_in_use
// clamped to 1..SLOTS) one per cycle, comparing tags and tracking the oldest
// use stamp, then the updated entry is written back. A hit stops the walk
// at the matching slot. A result sits in an output register, so the next
// transaction is accepted while it waits.
module rom_page_cache_lru_core #(
  parameter int SLOTS = rpc_pkg::SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rpc_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rpc_pkg::out_t                   out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rpc_pkg::ROM_LEN_W-1:0]   cfg_data
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_SCAN  = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  state_t                               state_r, state_nxt;
  rpc_pkg::in_t                         req_r, req_nxt;
  logic [SW-1:0]                        idx_r, idx_nxt;
  logic [SW-1:0]                        sel_r, sel_nxt;
  logic                                 hit_r, hit_nxt;
  logic [rpc_pkg::STAMP_W-1:0]          oldest_r, oldest_nxt;
  logic [rpc_pkg::STAMP_W-1:0]          stamp_r, stamp_nxt;
  logic [SLOTS-1:0]                     valid_r, valid_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  rpc_pkg::out_t                        out_r, out_nxt;
  logic [rpc_pkg::ROM_LEN_W-1:0]        rom_length_r, rom_length_nxt;
  logic [rpc_pkg::SLOTS_CFG_W-1:0]      slots_in_use_r, slots_in_use_nxt;

  logic                                 wr_en;
  logic [SW-1:0]                        wr_addr;
  rpc_pkg::entry_t                      wr_data;
  logic                                 rd_en;
  logic [SW-1:0]                        rd_addr;
  rpc_pkg::entry_t                      rd_data;

  logic [7:0]                           last_w;
  logic [SW-1:0]                        last_idx;
  logic                                 inv_found;
  logic [SW-1:0]                        inv_idx;
  logic [rpc_pkg::PAGE_BITS-1:0]        offset;
  logic [rpc_pkg::TAG_W-1:0]            tag;
  logic [rpc_pkg::ROM_LEN_W-1:0]        base;
  logic [rpc_pkg::ROM_LEN_W-1:0]        len_raw;
  logic [rpc_pkg::LEN_W-1:0]            fill_len;
  logic                                 out_free;

  rpc_entry_ram #(
    .DEPTH (SLOTS),
    .AW    (SW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  assign offset  = req_r.address[rpc_pkg::PAGE_BITS-1:0];
  assign tag     = req_r.address[rpc_pkg::ADDR_BITS-1:rpc_pkg::PAGE_BITS];
  assign base    = {1'b0, tag, {rpc_pkg::PAGE_BITS{1'b0}}};
  assign len_raw = rom_length_r - base;
  assign fill_len = (len_raw > rpc_pkg::ROM_LEN_W'(rpc_pkg::PAGE_SIZE))
                  ? rpc_pkg::LEN_W'(rpc_pkg::PAGE_SIZE)
                  : len_raw[rpc_pkg::LEN_W-1:0];

  // active slot count clamped to 1..SLOTS, as last index
  always_comb begin
    logic [7:0] su;
    su = {3'b0, slots_in_use_r};
    if (su == 8'd0) begin
      last_w = 8'd0;
    end else if (su > 8'(SLOTS)) begin
      last_w = 8'(SLOTS - 1);
    end else begin
      last_w = su - 8'd1;
    end
  end
  assign last_idx = last_w[SW-1:0];

  // lowest invalid active slot
  always_comb begin
    inv_found = 1'b0;
    inv_idx   = '0;
    for (int j = SLOTS - 1; j >= 0; j--) begin
      if (!valid_r[j] && (j <= int'(last_idx))) begin
        inv_found = 1'b1;
        inv_idx   = SW'(j);
      end
    end
  end

  assign rd_en   = (state_r == S_CHECK) || (state_r == S_SCAN);
  assign rd_addr = (state_r == S_CHECK) ? '0 : idx_r + SW'(1);

  always_comb begin
    logic [SW-1:0] victim;
    logic [31:0]   slot_ext;
    state_nxt        = state_r;
    req_nxt          = req_r;
    idx_nxt          = idx_r;
    sel_nxt          = sel_r;
    hit_nxt          = hit_r;
    oldest_nxt       = oldest_r;
    stamp_nxt        = stamp_r;
    valid_nxt        = valid_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_nxt          = out_r;
    rom_length_nxt   = rom_length_r;
    slots_in_use_nxt = slots_in_use_r;
    wr_en            = 1'b0;
    wr_addr          = '0;
    wr_data          = '0;
    victim           = '0;
    slot_ext         = '0;

    if (cfg_valid) begin
      case (cfg_index)
        rpc_pkg::REG_ROM_LENGTH:   rom_length_nxt = cfg_data;
        rpc_pkg::REG_SLOTS_IN_USE:
          slots_in_use_nxt = cfg_data[rpc_pkg::SLOTS_CFG_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        idx_nxt    = '0;
        sel_nxt    = '0;
        hit_nxt    = 1'b0;
        oldest_nxt = '1;
        if (req_r.req_type) begin
          if (out_free) begin
            valid_nxt     = '0;
            stamp_nxt     = '0;
            out_nxt       = '0;
            out_nxt.status = rpc_pkg::ST_FLUSH;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else if ({1'b0, req_r.address} >= rom_length_r) begin
          if (out_free) begin
            out_nxt        = '0;
            out_nxt.status = rpc_pkg::ST_OOR;
            out_valid_nxt  = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else if (32'(req_r.address) < rpc_pkg::FIXED_BANK_SIZE) begin
          if (out_free) begin
            out_nxt        = '0;
            out_nxt.status = rpc_pkg::ST_FIXED;
            out_nxt.offset = offset;
            out_valid_nxt  = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (valid_r[idx_r] && (rd_data.tag == tag)) begin
          hit_nxt   = 1'b1;
          sel_nxt   = idx_r;
          state_nxt = S_FIN;
        end else begin
          if (valid_r[idx_r] && (rd_data.stamp < oldest_r)) begin
            oldest_nxt = rd_data.stamp;
            sel_nxt    = idx_r;
          end
          if (idx_r == last_idx) begin
            state_nxt = S_FIN;
          end else begin
            idx_nxt = idx_r + SW'(1);
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          victim = (hit_r || !inv_found) ? sel_r : inv_idx;
          slot_ext = 32'(victim);
          stamp_nxt = stamp_r + 32'd1;
          wr_en   = 1'b1;
          wr_addr = victim;
          wr_data.tag   = tag;
          wr_data.stamp = stamp_r + 32'd1;
          valid_nxt[victim] = 1'b1;
          out_nxt        = '0;
          out_nxt.slot   = slot_ext[rpc_pkg::SLOT_W-1:0];
          out_nxt.offset = offset;
          if (hit_r) begin
            out_nxt.status = rpc_pkg::ST_HIT;
          end else begin
            out_nxt.status        = rpc_pkg::ST_MISS;
            out_nxt.fill_page     = tag;
            out_nxt.fill_length   = fill_len;
            out_nxt.evicted_valid = !inv_found;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      stamp_r        <= '0;
      valid_r        <= '0;
      out_valid_r    <= 1'b0;
      rom_length_r   <= '0;
      slots_in_use_r <= rpc_pkg::SLOTS_CFG_W'(rpc_pkg::SLOTS_RESET);
    end else begin
      state_r        <= state_nxt;
      stamp_r        <= stamp_nxt;
      valid_r        <= valid_nxt;
      out_valid_r    <= out_valid_nxt;
      rom_length_r   <= rom_length_nxt;
      slots_in_use_r <= slots_in_use_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    idx_r    <= idx_nxt;
    sel_r    <= sel_nxt;
    hit_r    <= hit_nxt;
    oldest_r <= oldest_nxt;
    out_r    <= out_nxt;
  end

endmodule

/* design/rpc_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the ROM page cache core, bound to the top level.
// Depends on rpc_pkg.
module rpc_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input rpc_pkg::out_t out_data
);

  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a transaction is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_flush_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == rpc_pkg::ST_FLUSH |->
      out_data.slot == '0 && out_data.offset == '0 && out_data.fill_page == '0 &&
      out_data.fill_length == '0 && !out_data.evicted_valid)
    else $error("flush transaction carries nonzero fields");

  a_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != rpc_pkg::ST_MISS |->
      out_data.fill_length == '0 && out_data.fill_page == '0 &&
      !out_data.evicted_valid)
    else $error("fill info outside a miss");

  a_fill_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == rpc_pkg::ST_MISS |->
      out_data.fill_length != '0 &&
      out_data.fill_length <= rpc_pkg::LEN_W'(rpc_pkg::PAGE_SIZE))
    else $error("miss fill length out of bounds");

endmodule

bind rom_page_cache_lru_core rpc_checker u_rpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* test/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for rom_page_cache_lru_core: drives ROM read lookups and flushes,
// predicts each classification, slot choice and fill request, and checks every result.
// Depends on rpc_pkg and the core RTL.
module testbench;

  localparam int QUIET_CYCLES      = rpc_pkg::SLOTS_DEF + 8;
  localparam int STALL_LIMIT       = 4000;
  localparam int HOLD_CYCLES       = 300;
  localparam int ITEMS_PER_SETTING = 205;

  localparam logic [rpc_pkg::ROM_LEN_W-1:0] ROM_SET [9] = '{
    24'h800000, 24'hFFFFFF, 24'h012345, 24'h0A0800, 24'h7FF001,
    24'h008000, 24'h3C5A17, 24'h100000, 24'h800000
  };
  localparam logic [rpc_pkg::SLOTS_CFG_W-1:0] SLOT_SET [9] = '{
    5'd16, 5'd4, 5'd1, 5'd31, 5'd0, 5'd2, 5'd9, 5'd3, 5'd16
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  rpc_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rpc_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rpc_pkg::CFG_IDX_W-1:0] cfg_index = rpc_pkg::REG_ROM_LENGTH;
  logic [rpc_pkg::ROM_LEN_W-1:0] cfg_data = '0;

  // predictor state
  logic [rpc_pkg::TAG_W-1:0]       slot_page [rpc_pkg::SLOTS_DEF];
  logic                            slot_live [rpc_pkg::SLOTS_DEF];
  logic [rpc_pkg::STAMP_W-1:0]     slot_used [rpc_pkg::SLOTS_DEF];
  logic [rpc_pkg::STAMP_W-1:0]     use_clock;
  logic [rpc_pkg::ROM_LEN_W-1:0]   cfg_rom_len;
  logic [rpc_pkg::SLOTS_CFG_W-1:0] cfg_slots;

  rpc_pkg::out_t pending_lookups [$];
  int   mismatches = 0;
  int   requests_sent = 0;
  int   status_seen [5] = '{default: 0};
  int   evictions = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   quiet_cycles = 0;
  int   hold_left = 0;
  logic hold_token = 1'b0;
  logic hold_seen = 1'b0;
  int   pool_base = 0;

  rom_page_cache_lru_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int active_slot_count();
    if (cfg_slots == 0) return 1;
    if (cfg_slots > rpc_pkg::SLOTS_DEF) return rpc_pkg::SLOTS_DEF;
    return cfg_slots;
  endfunction

  function automatic rpc_pkg::out_t predict_lookup(rpc_pkg::in_t req);
    rpc_pkg::out_t r;
    logic [rpc_pkg::TAG_W-1:0] page;
    logic [rpc_pkg::ROM_LEN_W-1:0] span;
    logic [rpc_pkg::STAMP_W-1:0] oldest;
    int n;
    int victim;
    r = '0;
    page = req.address[rpc_pkg::ADDR_BITS-1:rpc_pkg::PAGE_BITS];
    if (req.req_type) begin
      foreach (slot_live[j]) slot_live[j] = 1'b0;
      use_clock = '0;
      r.status = rpc_pkg::ST_FLUSH;
      return r;
    end
    if (req.address >= cfg_rom_len) begin
      r.status = rpc_pkg::ST_OOR;
      return r;
    end
    r.offset = req.address[rpc_pkg::PAGE_BITS-1:0];
    if (req.address < rpc_pkg::FIXED_BANK_SIZE) begin
      r.status = rpc_pkg::ST_FIXED;
      return r;
    end
    n = active_slot_count();
    for (int j = 0; j < n; j++) begin
      if (slot_live[j] && slot_page[j] == page) begin
        use_clock = use_clock + 1'b1;
        slot_used[j] = use_clock;
        r.status = rpc_pkg::ST_HIT;
        r.slot = rpc_pkg::SLOT_W'(j);
        return r;
      end
    end
    // first free slot, else least recently used (ties go to the lower slot)
    victim = 0;
    oldest = '1;
    for (int j = 0; j < n; j++) begin
      if (!slot_live[j]) begin
        victim = j;
        break;
      end
      if (slot_used[j] < oldest) begin
        oldest = slot_used[j];
        victim = j;
      end
    end
    span = cfg_rom_len - {1'b0, page, {rpc_pkg::PAGE_BITS{1'b0}}};
    r.status = rpc_pkg::ST_MISS;
    r.slot = rpc_pkg::SLOT_W'(victim);
    r.fill_page = page;
    r.fill_length = (span > rpc_pkg::PAGE_SIZE) ? rpc_pkg::LEN_W'(rpc_pkg::PAGE_SIZE)
                                                : span[rpc_pkg::LEN_W-1:0];
    r.evicted_valid = slot_live[victim];
    slot_page[victim] = page;
    use_clock = use_clock + 1'b1;
    slot_used[victim] = use_clock;
    slot_live[victim] = 1'b1;
    return r;
  endfunction

  function automatic rpc_pkg::in_t read_at(logic [rpc_pkg::ADDR_BITS-1:0] addr);
    return rpc_pkg::in_t'{1'b0, addr};
  endfunction

  // Mostly reads inside a working set a little larger than the active slots,
  // so hits, fills and evictions all show up; the rest probes the fixed bank, the ROM end and random addresses.
  function automatic rpc_pkg::in_t make_request();
    rpc_pkg::in_t req;
    int unsigned pick;
    int unsigned top_page;
    logic [rpc_pkg::ROM_LEN_W-1:0] last_byte;
    int page;
    req.req_type = ($urandom_range(99) < 3);
    req.address = rpc_pkg::ADDR_BITS'($urandom);
    pick = $urandom_range(99);
    last_byte = cfg_rom_len - 1'b1;
    top_page = last_byte[rpc_pkg::ROM_LEN_W-1:rpc_pkg::PAGE_BITS];
    if (top_page > (1 << rpc_pkg::TAG_W) - 1) top_page = (1 << rpc_pkg::TAG_W) - 1;
    if (pick < 72 && cfg_rom_len > rpc_pkg::FIXED_BANK_SIZE) begin
      if (pool_base < rpc_pkg::FIXED_BANK_SIZE / rpc_pkg::PAGE_SIZE ||
          $urandom_range(99) < 2)
        pool_base = $urandom_range(rpc_pkg::FIXED_BANK_SIZE / rpc_pkg::PAGE_SIZE,
                                   top_page);
      page = pool_base + $urandom_range(active_slot_count() + 2);
      if (page > top_page) page = top_page;
      req.address[rpc_pkg::ADDR_BITS-1:rpc_pkg::PAGE_BITS] = rpc_pkg::TAG_W'(page);
    end else if (pick < 82) begin
      req.address = rpc_pkg::ADDR_BITS'($urandom_range(rpc_pkg::FIXED_BANK_SIZE - 1));
    end else if (pick < 92) begin
      req.address = rpc_pkg::ADDR_BITS'(int'(cfg_rom_len) + $urandom_range(8) - 4);
    end
    return req;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  task automatic issue_request(rpc_pkg::in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    pending_lookups.push_back(predict_lookup(req));
    requests_sent++;
  endtask

  task automatic settle_cache();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_lookups.size() != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic program_cache(logic [rpc_pkg::ROM_LEN_W-1:0] rom_len,
                               logic [rpc_pkg::SLOTS_CFG_W-1:0] slots);
    settle_cache();
    cfg_valid <= 1'b1;
    cfg_index <= rpc_pkg::REG_ROM_LENGTH;
    cfg_data <= rom_len;
    do @(posedge clk); while (!cfg_ready);
    cfg_rom_len = rom_len;
    cfg_index <= rpc_pkg::REG_SLOTS_IN_USE;
    cfg_data <= rpc_pkg::ROM_LEN_W'(slots);
    do @(posedge clk); while (!cfg_ready);
    cfg_slots = slots;
    cfg_valid <= 1'b0;
    pool_base = 0;
  endtask

  // Reset leaves rom_length at zero: every read is out of range.
  task automatic test_after_reset();
    issue_request(read_at(23'h000000));
    issue_request(read_at(23'h7FFFFF));
    issue_request(rpc_pkg::in_t'{1'b1, 23'h7FFFFF});
  endtask

  // Fixed bank edges, page fills, a short last page, the ROM end and LRU eviction.
  task automatic test_address_classes();
    program_cache(24'h00A800, 5'd2);
    issue_request(read_at(23'h000000));
    issue_request(read_at(23'h007FFF));
    issue_request(read_at(23'h008000));
    issue_request(read_at(23'h008FFF));
    issue_request(read_at(23'h00A7FF));
    issue_request(read_at(23'h00A800));
    issue_request(read_at(23'h009123));
    issue_request(read_at(23'h008000));
  endtask

  // Slot count clamping, hidden slots keeping their pages, duplicate pages
  // resolved to the lowest slot, and a flush followed by a fresh fill.
  task automatic test_slot_count_limits();
    program_cache(24'h800000, 5'd0);
    issue_request(read_at(23'h7FFFFF));
    issue_request(read_at(23'h008ABC));
    program_cache(24'hFFFFFF, 5'd31);
    issue_request(read_at(23'h008001));
    issue_request(read_at(23'h00A000));
    issue_request(rpc_pkg::in_t'{1'b1, 23'h000000});
    issue_request(read_at(23'h008000));
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 8;
          recv_stall_pct <= 53;
        end
        1: begin
          send_idle_pct = 53;
          recv_stall_pct <= 8;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct <= 0;
        end
      endcase
      for (int k = 0; k < 3; k++) begin
        program_cache(ROM_SET[phase * 3 + k], SLOT_SET[phase * 3 + k]);
        repeat (ITEMS_PER_SETTING) issue_request(make_request());
      end
    end
  endtask

  // The receiver holds off while requests keep coming, so the core backs up.
  task automatic test_output_backpressure();
    program_cache(24'h400000, 5'd6);
    send_idle_pct = 0;
    hold_token <= ~hold_token;
    repeat (40) issue_request(make_request());
  endtask

  always @(posedge clk) begin : result_check
    rpc_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_lookups.size() == 0) begin
        report_mismatch("unexpected transaction", 32'(out_data), 32'd0);
      end else begin
        want = pending_lookups.pop_front();
        status_seen[int'(want.status)]++;
        if (want.evicted_valid) evictions++;
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
        if (out_data.slot !== want.slot)
          report_mismatch("slot", 32'(out_data.slot), 32'(want.slot));
        if (out_data.offset !== want.offset)
          report_mismatch("offset", 32'(out_data.offset), 32'(want.offset));
        if (out_data.fill_page !== want.fill_page)
          report_mismatch("fill_page", 32'(out_data.fill_page), 32'(want.fill_page));
        if (out_data.fill_length !== want.fill_length)
          report_mismatch("fill_length", 32'(out_data.fill_length), 32'(want.fill_length));
        if (out_data.evicted_valid !== want.evicted_valid)
          report_mismatch("evicted_valid", 32'(out_data.evicted_valid),
                          32'(want.evicted_valid));
      end
    end
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    foreach (slot_live[j]) begin
      slot_page[j] = '0;
      slot_live[j] = 1'b0;
      slot_used[j] = '0;
    end
    use_clock = '0;
    cfg_rom_len = '0;
    cfg_slots = rpc_pkg::SLOTS_CFG_W'(rpc_pkg::SLOTS_RESET);
    send_idle_pct = 8;
    recv_stall_pct <= 53;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_after_reset();
    test_address_classes();
    test_slot_count_limits();
    test_random_traffic();
    test_output_backpressure();
    settle_cache();
    $display("%0d requests over 13 cache settings, one of them under a long output stall",
             requests_sent);
    $display("results: %0d out of range, %0d fixed bank, %0d hits, %0d fills (%0d evicting),",
             status_seen[rpc_pkg::ST_OOR], status_seen[rpc_pkg::ST_FIXED],
             status_seen[rpc_pkg::ST_HIT], status_seen[rpc_pkg::ST_MISS], evictions);
    $display("  %0d flushes", status_seen[rpc_pkg::ST_FLUSH]);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
